### rtl/core/rfpa_pkg.sv
`timescale 1ns / 1ps

package rfpa_pkg;

  // gain format, unsigned Q(48-F).F
  localparam int GAIN_FRACTION_BITS = 24;
  localparam int KU_SHIFT = 32 - GAIN_FRACTION_BITS;

  // floor(2^32 / pi)
  localparam logic [30:0] INVPI_Q32 = 31'd1367130551;

  // shared multiply / divide unit
  localparam int MD_AW = 96;
  localparam int MD_BW = 48;
  localparam int MD_CW = $clog2(MD_AW + 1);

  localparam logic MD_OP_MUL = 1'b0;
  localparam logic MD_OP_DIV = 1'b1;

  // outcome codes
  localparam logic [1:0] OUTCOME_NONE    = 2'd0;
  localparam logic [1:0] OUTCOME_DONE    = 2'd1;
  localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;
  localparam logic [1:0] OUTCOME_DEGEN   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_HYST    = 3'd1;
  localparam logic [2:0] REG_AMP     = 3'd2;
  localparam logic [2:0] REG_CYCLES  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic start;
    logic op;
  } md_req_t;

  function automatic logic [47:0] sat48(input logic [MD_AW-1:0] x);
    logic [47:0] r;
    r = (|x[MD_AW-1:48]) ? 48'hFFFF_FFFF_FFFF : x[47:0];
    return r;
  endfunction

endpackage

### rtl/core/rfpa_muldiv.sv
`timescale 1ns / 1ps

// shift-add multiplier and restoring divider sharing the accumulator and counter registers
module rfpa_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  rfpa_pkg::md_req_t              req,
  input  logic [rfpa_pkg::MD_AW-1:0]     a,
  input  logic [rfpa_pkg::MD_BW-1:0]     b,
  output logic                           done,
  output logic [rfpa_pkg::MD_AW-1:0]     result
);

  logic                           busy;
  logic                           op;
  logic [rfpa_pkg::MD_CW-1:0]     cnt;
  logic [rfpa_pkg::MD_AW-1:0]     acc;
  logic [rfpa_pkg::MD_AW-1:0]     mc;
  logic [rfpa_pkg::MD_BW-1:0]     mp;
  logic [rfpa_pkg::MD_BW-1:0]     rem;
  logic [rfpa_pkg::MD_BW-1:0]     dvs;
  logic [rfpa_pkg::MD_BW:0]       trial;
  logic                           fits;

  assign trial  = {rem, acc[rfpa_pkg::MD_AW-1]};
  assign fits   = trial >= {1'b0, dvs};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        if (req.op == rfpa_pkg::MD_OP_MUL) begin
          acc <= '0;
          mc  <= {{(rfpa_pkg::MD_AW-rfpa_pkg::MD_BW){1'b0}}, a[rfpa_pkg::MD_BW-1:0]};
          mp  <= b;
          cnt <= rfpa_pkg::MD_CW'(rfpa_pkg::MD_BW);
        end else begin
          acc <= a;
          rem <= '0;
          dvs <= b;
          cnt <= rfpa_pkg::MD_CW'(rfpa_pkg::MD_AW);
        end
      end else if (busy) begin
        if (op == rfpa_pkg::MD_OP_MUL) begin
          if (mp[0]) acc <= acc + mc;
          mc <= {mc[rfpa_pkg::MD_AW-2:0], 1'b0};
          mp <= {1'b0, mp[rfpa_pkg::MD_BW-1:1]};
        end else begin
          // one quotient bit a cycle
          rem <= fits ? rfpa_pkg::MD_BW'(trial - {1'b0, dvs}) : trial[rfpa_pkg::MD_BW-1:0];
          acc <= {acc[rfpa_pkg::MD_AW-2:0], fits};
        end
        cnt <= cnt - 1'b1;
        if (cnt == rfpa_pkg::MD_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/relay_feedback_pid_autotune.sv
`timescale 1ns / 1ps
// relay-feedback autotune with ziegler-nichols gains, one result item per input item
// one item at a time: a new input item is taken only in idle, once the last result is in the output
//   register; a sample that closes an oscillation and the finish use the 96-step shift-subtract
//   divider and 48-step shift-add multiplier of the shared unit, and the finish also uses the
//   shift-add divide by ten
// reset: synchronous rst clears the run state and gains and loads register defaults
module relay_feedback_pid_autotune (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic               firing_allowed,
  input  logic [31:0]        time_ms,
  input  logic signed [15:0] temperature,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               heater_on,
  output logic               tuning_active,
  output logic [1:0]         outcome,
  output logic [7:0]         cycle_count,
  output logic [31:0]        period_ms,
  output logic [47:0]        gain_p,
  output logic [47:0]        gain_i,
  output logic [47:0]        gain_d,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // sequencer codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EVAL     = 4'd1;
  localparam logic [3:0] S_MEAN_MUL = 4'd2;
  localparam logic [3:0] S_MEAN_DIV = 4'd3;
  localparam logic [3:0] S_KU_DIV   = 4'd4;
  localparam logic [3:0] S_FIN      = 4'd5;
  localparam logic [3:0] S_KP_DIV   = 4'd6;
  localparam logic [3:0] S_KI_DIV   = 4'd7;
  localparam logic [3:0] S_KD_MUL   = 4'd8;
  localparam logic [3:0] S_KD_DIV   = 4'd9;
  localparam logic [3:0] S_TIMEOUT  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  localparam int AW = rfpa_pkg::MD_AW;
  localparam int BW = rfpa_pkg::MD_BW;

  // configuration registers
  logic signed [15:0] target_temp;
  logic [9:0]         hysteresis;
  logic [6:0]         relay_amplitude;
  logic [7:0]         cycles_needed;
  logic [31:0]        timeout_ms;

  // run state
  logic [3:0]         state;
  logic               tuning_flag;
  logic               relay_state;
  logic [31:0]        run_start_time;
  logic [31:0]        last_toggle_time;
  logic signed [15:0] peak_temp;
  logic signed [15:0] trough_temp;
  logic [7:0]         oscillations;
  logic [39:0]        period_mean;
  logic [47:0]        ultimate_gain;
  logic [47:0]        held_gains [3];
  logic [1:0]         outcome_r;

  // latched item
  logic               it_action;
  logic               it_allowed;
  logic [31:0]        it_time;
  logic signed [15:0] it_temp;
  logic [31:0]        period_r;

  // shared unit
  rfpa_pkg::md_req_t  md_req;
  logic [AW-1:0]      md_a;
  logic [BW-1:0]      md_b;
  logic               md_done;
  logic [AW-1:0]      md_res;

  // divide by ten: shift-add reciprocal estimate, then one correction
  logic [51:0]        d10_x;
  logic [51:0]        d10_q;
  logic [4:0]         d10_r;
  logic [2:0]         d10_step;
  logic               d10_run;
  logic               d10_sat;
  logic [51:0]        d10_tenq;
  logic [51:0]        d10_res;

  rfpa_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (md_a),
    .b      (md_b),
    .done   (md_done),
    .result (md_res)
  );

  // sample decisions
  logic signed [16:0] temp17;
  logic signed [16:0] on_thresh;
  logic signed [16:0] swing;
  logic [31:0]        since_toggle;
  logic [31:0]        elapsed;
  logic [37:0]        amp_prod;
  logic [44:0]        ku_num;
  logic [BW-1:0]      ku_den;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign temp17       = {it_temp[15], it_temp};
  assign on_thresh    = {target_temp[15], target_temp} - $signed({7'b0, hysteresis});
  assign swing        = {peak_temp[15], peak_temp} - {trough_temp[15], trough_temp};
  assign since_toggle = it_time - last_toggle_time;
  assign elapsed      = it_time - run_start_time;
  // ku = 128 d invpi / (swing << (32-F))
  assign amp_prod     = relay_amplitude * rfpa_pkg::INVPI_Q32;
  assign ku_num       = {amp_prod, 7'b0};
  assign ku_den       = {32'b0, swing[15:0]} << rfpa_pkg::KU_SHIFT;

  // estimate is low by at most one, the remainder decides the last step
  assign d10_run  = (state == S_KP_DIV) || (state == S_KD_DIV);
  assign d10_tenq = (d10_q << 3) + (d10_q << 1);
  assign d10_res  = d10_q + {51'b0, (d10_r > 5'd9)};

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      rfpa_pkg::REG_TARGET:  prdata = {{16{target_temp[15]}}, target_temp};
      rfpa_pkg::REG_HYST:    prdata = {22'b0, hysteresis};
      rfpa_pkg::REG_AMP:     prdata = {25'b0, relay_amplitude};
      rfpa_pkg::REG_CYCLES:  prdata = {24'b0, cycles_needed};
      rfpa_pkg::REG_TIMEOUT: prdata = timeout_ms;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp     <= 16'sd1600;
      hysteresis      <= 10'd8;
      relay_amplitude <= 7'd50;
      cycles_needed   <= 8'd5;
      timeout_ms      <= 32'd7200000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rfpa_pkg::REG_TARGET:  target_temp     <= pwdata[15:0];
        rfpa_pkg::REG_HYST:    hysteresis      <= pwdata[9:0];
        rfpa_pkg::REG_AMP:     relay_amplitude <= pwdata[6:0];
        rfpa_pkg::REG_CYCLES:  cycles_needed   <= pwdata[7:0];
        rfpa_pkg::REG_TIMEOUT: timeout_ms      <= pwdata;
        default: ;
      endcase
    end
  end

  // divide by ten, one step a cycle while running, result ready at step seven
  always_ff @(posedge clk) begin
    if (rst) begin
      d10_step <= '0;
      d10_q    <= '0;
      d10_r    <= '0;
    end else if (!d10_run) begin
      d10_step <= '0;
    end else if (d10_step != 3'd7) begin
      case (d10_step)
        3'd0:    d10_q <= (d10_x >> 1) + (d10_x >> 2);
        3'd1:    d10_q <= d10_q + (d10_q >> 4);
        3'd2:    d10_q <= d10_q + (d10_q >> 8);
        3'd3:    d10_q <= d10_q + (d10_q >> 16);
        3'd4:    d10_q <= d10_q + (d10_q >> 32);
        3'd5:    d10_q <= d10_q >> 3;
        default: d10_r <= 5'(d10_x - d10_tenq);
      endcase
      d10_step <= d10_step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tuning_flag      <= 1'b0;
      relay_state      <= 1'b0;
      run_start_time   <= '0;
      last_toggle_time <= '0;
      peak_temp        <= -16'sd32768;
      trough_temp      <= 16'sd32767;
      oscillations     <= '0;
      period_mean      <= '0;
      ultimate_gain    <= '0;
      held_gains[0]    <= '0;
      held_gains[1]    <= '0;
      held_gains[2]    <= '0;
      outcome_r        <= rfpa_pkg::OUTCOME_NONE;
      out_valid        <= 1'b0;
      md_req           <= '0;
    end else begin
      md_req.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_action  <= action;
            it_allowed <= firing_allowed;
            it_time    <= time_ms;
            it_temp    <= temperature;
            outcome_r  <= rfpa_pkg::OUTCOME_NONE;
            state      <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (!it_allowed) begin
            state <= S_OUT;
          end else if (!it_action) begin
            // start item: fresh run, heater on
            tuning_flag      <= 1'b1;
            relay_state      <= 1'b1;
            run_start_time   <= it_time;
            last_toggle_time <= it_time;
            peak_temp        <= -16'sd32768;
            trough_temp      <= 16'sd32767;
            oscillations     <= '0;
            period_mean      <= '0;
            ultimate_gain    <= '0;
            state            <= S_OUT;
          end else if (!tuning_flag) begin
            state <= S_OUT;
          end else if (relay_state && (it_temp >= target_temp)) begin
            relay_state      <= 1'b0;
            last_toggle_time <= it_time;
            if (it_temp > peak_temp) peak_temp <= it_temp;
            state <= S_TIMEOUT;
          end else if (!relay_state && (temp17 <= on_thresh)) begin
            // oscillation closes: period is twice the off time
            relay_state      <= 1'b1;
            last_toggle_time <= it_time;
            if (it_temp < trough_temp) trough_temp <= it_temp;
            period_r   <= since_toggle[31] ? 32'hFFFF_FFFF : {since_toggle[30:0], 1'b0};
            md_req     <= '{start: 1'b1, op: rfpa_pkg::MD_OP_MUL};
            md_a       <= {56'b0, period_mean};
            md_b       <= {40'b0, oscillations};
            state      <= S_MEAN_MUL;
          end else begin
            state <= S_TIMEOUT;
          end
        end

        S_MEAN_MUL: begin
          if (md_done) begin
            md_req <= '{start: 1'b1, op: rfpa_pkg::MD_OP_DIV};
            md_a   <= md_res + {56'b0, period_r, 8'b0};
            md_b   <= {39'b0, {1'b0, oscillations} + 9'd1};
            state  <= S_MEAN_DIV;
          end
        end

        S_MEAN_DIV: begin
          if (md_done) begin
            period_mean <= md_res[39:0];
            if (oscillations != 8'hFF) oscillations <= oscillations + 8'd1;
            if (!swing[16] && (swing != 17'sd0)) begin
              md_req <= '{start: 1'b1, op: rfpa_pkg::MD_OP_DIV};
              md_a   <= {51'b0, ku_num};
              md_b   <= ku_den;
              state  <= S_KU_DIV;
            end else begin
              state <= S_FIN;
            end
          end
        end

        S_KU_DIV: begin
          if (md_done) begin
            ultimate_gain <= rfpa_pkg::sat48(md_res);
            state         <= S_FIN;
          end
        end

        S_FIN: begin
          if (oscillations >= cycles_needed) begin
            tuning_flag <= 1'b0;
            relay_state <= 1'b0;
            if ((ultimate_gain == '0) || (period_mean == '0)) begin
              outcome_r <= rfpa_pkg::OUTCOME_DEGEN;
              state     <= S_OUT;
            end else begin
              // kp = 6 ku / 10
              d10_x <= ({4'b0, ultimate_gain} << 2) + ({4'b0, ultimate_gain} << 1);
              state <= S_KP_DIV;
            end
          end else begin
            state <= S_TIMEOUT;
          end
        end

        S_KP_DIV: begin
          if (d10_step == 3'd7) begin
            held_gains[0] <= d10_res[47:0];
            // ki = 3072 ku / (10 tq)
            md_req <= '{start: 1'b1, op: rfpa_pkg::MD_OP_DIV};
            md_a   <= ({48'b0, ultimate_gain} << 11) + ({48'b0, ultimate_gain} << 10);
            md_b   <= ({8'b0, period_mean} << 3) + ({8'b0, period_mean} << 1);
            state  <= S_KI_DIV;
          end
        end

        S_KI_DIV: begin
          if (md_done) begin
            held_gains[1] <= rfpa_pkg::sat48(md_res);
            // kd = ku 3 tq / 10240
            md_req <= '{start: 1'b1, op: rfpa_pkg::MD_OP_MUL};
            md_a   <= {48'b0, ultimate_gain};
            md_b   <= ({8'b0, period_mean} << 1) + {8'b0, period_mean};
            state  <= S_KD_MUL;
          end
        end

        S_KD_MUL: begin
          if (md_done) begin
            // drop 1024 by shifting, a quotient past 2^52 / 10 saturates anyway
            d10_sat <= |md_res[AW-1:62];
            d10_x   <= md_res[61:10];
            state   <= S_KD_DIV;
          end
        end

        S_KD_DIV: begin
          if (d10_step == 3'd7) begin
            held_gains[2] <= (d10_sat || (|d10_res[51:48])) ? 48'hFFFF_FFFF_FFFF
                                                            : d10_res[47:0];
            outcome_r     <= rfpa_pkg::OUTCOME_DONE;
            state         <= S_OUT;
          end
        end

        S_TIMEOUT: begin
          if (elapsed > timeout_ms) begin
            tuning_flag <= 1'b0;
            relay_state <= 1'b0;
            outcome_r   <= rfpa_pkg::OUTCOME_TIMEOUT;
          end
          state <= S_OUT;
        end

        S_OUT: begin
          // wait for the output slot, then show the state as the item leaves it
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            heater_on     <= relay_state;
            tuning_active <= tuning_flag;
            outcome       <= outcome_r;
            cycle_count   <= oscillations;
            period_ms     <= period_mean[39:8];
            gain_p        <= held_gains[0];
            gain_i        <= held_gains[1];
            gain_d        <= held_gains[2];
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
